// ===== hdl/rdbc_pkg.sv =====
package rdbc_pkg;

    // coordinate and random fraction widths
    localparam int CW = 32;
    localparam int RB = 16;

    // quotient bits produced by the divider; larger offsets saturate anyway
    localparam int QB = 41;

    // full product width of length times abs(diff)
    localparam int PW = 2 * CW - 1;

    // fixed mask codes
    localparam logic [1:0] FIX_NONE   = 2'd0;
    localparam logic [1:0] FIX_FIRST  = 2'd1;
    localparam logic [1:0] FIX_SECOND = 2'd2;
    localparam logic [1:0] FIX_BOTH   = 2'd3;

endpackage

// ===== hdl/random_distance_bound_correction.sv =====
// channel   | direction | handshake              | contents
// ----------+-----------+------------------------+----------------------------------
// request   | in        | start, busy            | coordinates, distance, bounds, flags
// result    | out       | done (one-cycle)       | new_x1_coord, new_x2_coord
// config    | in        | cfg_valid, cfg_ready   | cfg_data -> length_mode
//
// one request per cycle, results return in request order
// most of the pipeline is the restoring divider, one quotient bit per stage
// busy stays low and cfg_ready stays high, the pipeline never holds
// rst_n clears valid bits and length_mode, data registers are not reset
// the receiver cannot stall, each result is shown for exactly one cycle
module random_distance_bound_correction
    import rdbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [CW-1:0] x1_coord,
    input  logic signed [CW-1:0] x2_coord,
    input  logic signed [CW-1:0] diff_coord,
    input  logic        [CW-2:0] pair_distance,
    input  logic        [CW-2:0] lower_bound,
    input  logic        [CW-2:0] upper_bound,
    input  logic                 is_bond,
    input  logic        [RB-1:0] random_fraction,
    input  logic        [1:0]    fixed_mask,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    output logic                 done,
    output logic signed [CW-1:0] new_x1_coord,
    output logic signed [CW-1:0] new_x2_coord
);

    // context carried alongside the divider
    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] x2;
        logic signed [CW:0]   mid;
        logic [1:0]           fixed;
        logic                 dz;
        logic                 neg;
        logic                 ovf;
        logic [CW-1:0]        den;
    } ctx_t;

    localparam int SPW = CW + 1 + RB + 3;

    logic mode_reg;

    // stage 1 registers
    logic                 v1_reg;
    logic signed [CW:0]   span1_reg;
    logic [RB+1:0]        r1_reg;
    logic                 bond1_reg;
    logic [CW-2:0]        lb1_reg;
    logic signed [CW-1:0] x1_1_reg, x2_1_reg, diff1_reg;
    logic [CW-2:0]        d1_reg;
    logic [1:0]           fix1_reg;
    logic signed [CW:0]   mid1_reg;

    // stage 2 registers
    logic                  v2_reg;
    logic signed [SPW-1:0] sp2_reg;
    logic                  bond2_reg;
    logic [CW-2:0]         lb2_reg;
    logic signed [CW-1:0]  x1_2_reg, x2_2_reg, diff2_reg;
    logic [CW-2:0]         d2_reg;
    logic [1:0]            fix2_reg;
    logic signed [CW:0]    mid2_reg;

    // stage 3 registers
    logic                 v3_reg;
    logic [CW-2:0]        len3_reg;
    logic [CW-1:0]        absd3_reg;
    ctx_t                 ctx3_reg;

    // stage 4 registers
    logic                 v4_reg;
    logic [PW-1:0]        prod4_reg;
    ctx_t                 ctx4_reg;

    // divider pipeline
    logic                 dv_reg   [QB+1];
    ctx_t                 dctx_reg [QB+1];
    logic [CW-1:0]        drem_reg [QB+1];
    logic [QB-1:0]        dlow_reg [QB+1];
    logic [QB-1:0]        dq_reg   [QB+1];

    // offset stage
    logic                 vo_reg;
    logic signed [QB+2:0] off_reg;
    ctx_t                 ctxo_reg;

    // output registers
    logic                 done_reg;
    logic signed [CW-1:0] n1_reg, n2_reg;

    logic signed [SPW-1:0] sp_shift;
    logic signed [CW+1:0]  len_next;
    logic [CW-1:0]         absd_next;
    logic [CW-1:0]         den_next;
    logic [PW-QB-1:0]      prod_top;
    ctx_t                  ctx_entry;
    logic [QB:0]           mag_next;
    logic signed [QB+2:0]  off_next;
    logic signed [QB+4:0]  a1, a2;
    logic signed [CW-1:0]  n1_next, n2_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // length mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // valid chain through the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg    <= start;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
        end
    end

    // stage 1: span, scaled random draw, midpoint
    always_ff @(posedge clk)
    begin
        span1_reg <= $signed({2'b00, upper_bound}) - $signed({2'b00, lower_bound});
        r1_reg    <= is_bond ? ({2'b00, random_fraction} + {1'b0, random_fraction, 1'b0})
                             : {2'b00, random_fraction};
        bond1_reg <= is_bond;
        lb1_reg   <= lower_bound;
        x1_1_reg  <= x1_coord;
        x2_1_reg  <= x2_coord;
        diff1_reg <= diff_coord;
        d1_reg    <= pair_distance;
        fix1_reg  <= fixed_mask;
        mid1_reg  <= {x1_coord[CW-1], x1_coord}
                     + {{2{diff_coord[CW-1]}}, diff_coord[CW-1:1]};
    end

    // stage 2: span times draw
    always_ff @(posedge clk)
    begin
        sp2_reg   <= SPW'(span1_reg * $signed({1'b0, r1_reg}));
        bond2_reg <= bond1_reg;
        lb2_reg   <= lb1_reg;
        x1_2_reg  <= x1_1_reg;
        x2_2_reg  <= x2_1_reg;
        diff2_reg <= diff1_reg;
        d2_reg    <= d1_reg;
        fix2_reg  <= fix1_reg;
        mid2_reg  <= mid1_reg;
    end

    // stage 3: new length, divisor, direction magnitude
    always_comb
    begin
        sp_shift  = bond2_reg ? (sp2_reg >>> (RB + 2)) : (sp2_reg >>> RB);
        len_next  = $signed({3'b000, lb2_reg}) + (CW+2)'(sp_shift);
        absd_next = diff2_reg[CW-1] ? (~diff2_reg + 1'b1) : diff2_reg;
        den_next  = (fix2_reg == FIX_NONE) ? {d2_reg, 1'b0} : {1'b0, d2_reg};
    end

    always_ff @(posedge clk)
    begin
        len3_reg        <= mode_reg ? '0 : len_next[CW-2:0];
        absd3_reg       <= absd_next;
        ctx3_reg.x1     <= x1_2_reg;
        ctx3_reg.x2     <= x2_2_reg;
        ctx3_reg.mid    <= mid2_reg;
        ctx3_reg.fixed  <= fix2_reg;
        ctx3_reg.dz     <= (d2_reg == '0);
        ctx3_reg.neg    <= diff2_reg[CW-1];
        ctx3_reg.ovf    <= 1'b0;
        ctx3_reg.den    <= den_next;
    end

    // stage 4: length times abs(diff)
    always_ff @(posedge clk)
    begin
        prod4_reg <= PW'({1'b0, len3_reg} * absd3_reg);
        ctx4_reg  <= ctx3_reg;
    end

    // divider entry: overflow check and initial partial remainder
    assign prod_top = prod4_reg[PW-1:QB];

    always_comb
    begin
        ctx_entry     = ctx4_reg;
        ctx_entry.ovf = ({{(CW-(PW-QB)){1'b0}}, prod_top} >= ctx4_reg.den);
    end

    always_ff @(posedge clk)
    begin
        dctx_reg[0]     <= ctx_entry;
        drem_reg[0]     <= {{(CW-(PW-QB)){1'b0}}, prod_top};
        dlow_reg[0]     <= prod4_reg[QB-1:0];
        dq_reg[0]       <= '0;
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < QB; i++)
    begin : g_div
        logic [CW:0]   rem2;
        logic          take;
        logic [CW-1:0] rem_next;

        always_comb
        begin
            rem2     = {drem_reg[i], dlow_reg[i][QB-1]};
            take     = (rem2 >= {1'b0, dctx_reg[i].den});
            rem_next = take ? CW'(rem2 - {1'b0, dctx_reg[i].den}) : rem2[CW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i+1] <= 1'b0;
            end
            else
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            dctx_reg[i+1] <= dctx_reg[i];
            drem_reg[i+1] <= rem_next;
            dlow_reg[i+1] <= {dlow_reg[i][QB-2:0], 1'b0};
            dq_reg[i+1]   <= {dq_reg[i][QB-2:0], take};
        end
    end

    // signed offset with floor rounding and limit
    always_comb
    begin
        if (dctx_reg[QB].ovf)
        begin
            mag_next = {1'b1, {QB{1'b0}}};
        end
        else
        begin
            mag_next = {1'b0, dq_reg[QB]}
                       + (QB+1)'(dctx_reg[QB].neg && (drem_reg[QB] != '0));
        end
        if (dctx_reg[QB].dz)
        begin
            off_next = '0;
        end
        else if (dctx_reg[QB].neg)
        begin
            off_next = -$signed({2'b00, mag_next});
        end
        else
        begin
            off_next = $signed({2'b00, mag_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vo_reg   <= dv_reg[QB];
            done_reg <= vo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        ctxo_reg <= dctx_reg[QB];
    end

    // apply offsets per fixed mask and saturate
    function automatic logic signed [CW-1:0] sat(input logic signed [QB+4:0] v);
        logic signed [QB+4:0] hi;
        logic signed [QB+4:0] lo;
        hi = (QB+5)'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)
        begin
            sat = hi[CW-1:0];
        end
        else if (v < lo)
        begin
            sat = lo[CW-1:0];
        end
        else
        begin
            sat = v[CW-1:0];
        end
    endfunction

    always_comb
    begin
        a1 = (QB+5)'(ctxo_reg.x1);
        a2 = (QB+5)'(ctxo_reg.x2);
        case (ctxo_reg.fixed)
            FIX_NONE:
            begin
                a1 = (QB+5)'(ctxo_reg.mid) - (QB+5)'(off_reg);
                a2 = (QB+5)'(ctxo_reg.mid) + (QB+5)'(off_reg);
            end
            FIX_FIRST:
            begin
                a2 = (QB+5)'(ctxo_reg.x1) + (QB+5)'(off_reg);
            end
            FIX_SECOND:
            begin
                a1 = (QB+5)'(ctxo_reg.x2) - (QB+5)'(off_reg);
            end
            default:
            begin
                a1 = (QB+5)'(ctxo_reg.x1);
            end
        endcase
        n1_next = sat(a1);
        n2_next = sat(a2);
    end

    always_ff @(posedge clk)
    begin
        n1_reg <= n1_next;
        n2_reg <= n2_next;
    end

    assign done         = done_reg;
    assign new_x1_coord = n1_reg;
    assign new_x2_coord = n2_reg;

endmodule

// ===== tb/random_distance_bound_correction_tb.sv =====
`timescale 1ns / 1ps

module random_distance_bound_correction_tb;
    import rdbc_pkg::*;

    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [63:0] OFFSET_CAP = 64'd1 << 62;

    typedef struct {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] diff;
        logic        [CW-2:0] pdist;
        logic        [CW-2:0] lb;
        logic        [CW-2:0] ub;
        logic                 bond;
        logic        [RB-1:0] frac;
        logic        [1:0]    mask;
    } axis_req_t;

    typedef struct {
        logic signed [CW-1:0] nx1;
        logic signed [CW-1:0] nx2;
    } axis_pos_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] x1_coord;
    logic signed [CW-1:0] x2_coord;
    logic signed [CW-1:0] diff_coord;
    logic        [CW-2:0] pair_distance;
    logic        [CW-2:0] lower_bound;
    logic        [CW-2:0] upper_bound;
    logic                 is_bond;
    logic        [RB-1:0] random_fraction;
    logic        [1:0]    fixed_mask;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    logic                 done;
    logic signed [CW-1:0] new_x1_coord;
    logic signed [CW-1:0] new_x2_coord;

    axis_req_t pending_reqs[$];
    axis_pos_t expected_pos[$];
    logic      mode_q;
    logic      hold_off;
    int        error_count;
    int        cycle_count;
    int        burst_left;
    int        gap_left;

    random_distance_bound_correction dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .x1_coord        (x1_coord),
        .x2_coord        (x2_coord),
        .diff_coord      (diff_coord),
        .pair_distance   (pair_distance),
        .lower_bound     (lower_bound),
        .upper_bound     (upper_bound),
        .is_bond         (is_bond),
        .random_fraction (random_fraction),
        .fixed_mask      (fixed_mask),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .done            (done),
        .new_x1_coord    (new_x1_coord),
        .new_x2_coord    (new_x2_coord)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // floor(a*b/den) with the magnitude capped at 2^62
    function automatic logic signed [63:0] scaled_quot(input logic signed [63:0] a,
                                                       input logic [63:0] b,
                                                       input logic [63:0] den);
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] rem;
        logic [63:0]  mag;
        logic         neg;
        if (den == 64'd0)
            return 64'sd0;
        neg  = a < 0;
        mag  = neg ? -a : a;
        prod = {64'd0, mag} * {64'd0, b};
        q    = prod / {64'd0, den};
        rem  = prod % {64'd0, den};
        if (q > {64'd0, OFFSET_CAP})
            q = {64'd0, OFFSET_CAP};
        if (neg)
        begin
            if (rem != 0 && q < {64'd0, OFFSET_CAP})
                q = q + 1;
            return -$signed(q[63:0]);
        end
        return $signed(q[63:0]);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[CW-1:0];
    endfunction

    // expected new coordinates for one axis
    function automatic axis_pos_t correct_axis(input axis_req_t rq, input logic mode);
        axis_pos_t         res;
        logic signed [63:0] x1, x2, diff, lb, ub, span, newlen, midp, off, n1, n2;
        logic [63:0]       d, dmag;
        x1     = rq.x1;
        x2     = rq.x2;
        diff   = rq.diff;
        d      = {33'd0, rq.pdist};
        lb     = {33'd0, rq.lb};
        ub     = {33'd0, rq.ub};
        newlen = 0;
        if (mode == 1'b0)
        begin
            span = ub - lb;
            if (rq.bond)
                newlen = lb + scaled_quot(span, 64'd3 * rq.frac, 64'd1 << (RB + 2));
            else
                newlen = lb + scaled_quot(span, {48'd0, rq.frac}, 64'd1 << RB);
        end
        midp = x1 + (diff >>> 1);
        dmag = diff < 0 ? -diff : diff;
        n1   = x1;
        n2   = x2;
        off  = 0;
        if (rq.mask == FIX_NONE)
        begin
            if (d != 0)
                off = scaled_quot(diff < 0 ? -newlen : newlen, dmag, 2 * d);
            n1 = midp - off;
            n2 = midp + off;
        end
        else if (rq.mask != FIX_BOTH)
        begin
            if (d != 0)
                off = scaled_quot(diff < 0 ? -newlen : newlen, dmag, d);
            if (rq.mask == FIX_FIRST)
                n2 = x1 + off;
            else
                n1 = x2 - off;
        end
        res.nx1 = clamp_coord(n1);
        res.nx2 = clamp_coord(n2);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // request driver, bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n && gap_left == 0 && !hold_off && pending_reqs.size() > 0)
        begin
            start           <= 1'b1;
            x1_coord        <= pending_reqs[0].x1;
            x2_coord        <= pending_reqs[0].x2;
            diff_coord      <= pending_reqs[0].diff;
            pair_distance   <= pending_reqs[0].pdist;
            lower_bound     <= pending_reqs[0].lb;
            upper_bound     <= pending_reqs[0].ub;
            is_bond         <= pending_reqs[0].bond;
            random_fraction <= pending_reqs[0].frac;
            fixed_mask      <= pending_reqs[0].mask;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        else
        begin
            start <= 1'b0;
            if (gap_left > 0)
                gap_left--;
        end
    end

    // accept requests, check results, count cycles
    always @(posedge clk)
    begin
        axis_req_t rq;
        axis_pos_t exp_pos;
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (start && !busy && pending_reqs.size() > 0)
            begin
                rq = pending_reqs.pop_front();
                expected_pos.push_back(correct_axis(rq, mode_q));
            end
            if (done)
            begin
                if (expected_pos.size() == 0)
                    report_mismatch("result with none expected");
                else
                begin
                    exp_pos = expected_pos.pop_front();
                    if (new_x1_coord !== exp_pos.nx1)
                        report_mismatch($sformatf("new_x1_coord %h expected %h",
                                                  new_x1_coord, exp_pos.nx1));
                    if (new_x2_coord !== exp_pos.nx2)
                        report_mismatch($sformatf("new_x2_coord %h expected %h",
                                                  new_x2_coord, exp_pos.nx2));
                end
            end
        end
    end

    function automatic axis_req_t make_req(input logic signed [CW-1:0] x1,
                                           input logic signed [CW-1:0] x2,
                                           input logic signed [CW-1:0] diff,
                                           input logic [CW-2:0] pdist,
                                           input logic [CW-2:0] lb,
                                           input logic [CW-2:0] ub,
                                           input logic bond,
                                           input logic [RB-1:0] frac,
                                           input logic [1:0] mask);
        axis_req_t rq;
        rq.x1 = x1; rq.x2 = x2; rq.diff = diff; rq.pdist = pdist;
        rq.lb = lb; rq.ub = ub; rq.bond = bond; rq.frac = frac; rq.mask = mask;
        return rq;
    endfunction

    function automatic logic signed [CW-1:0] small_coord();
        return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
    endfunction

    // one pair, three axes sharing distance, bounds, flag and fraction
    task automatic queue_pair();
        logic signed [CW-1:0] ax1[3];
        logic signed [CW-1:0] ax2[3];
        logic [CW-2:0]        pdist, lb, ub;
        logic                 bond;
        logic [RB-1:0]        frac;
        logic [1:0]           mask;
        int                   longest;
        longest = 0;
        for (int i = 0; i < 3; i++)
        begin
            ax1[i] = small_coord();
            ax2[i] = small_coord();
            if ((ax2[i] - ax1[i] > 0 ? ax2[i] - ax1[i] : ax1[i] - ax2[i]) > longest)
                longest = ax2[i] - ax1[i] > 0 ? ax2[i] - ax1[i] : ax1[i] - ax2[i];
        end
        pdist = ($urandom_range(0, 15) == 0) ? 31'd0 :
                (CW-1)'(longest + $urandom_range(0, 32'h10000));
        lb    = (CW-1)'($urandom_range(0, 32'h00080000));
        ub    = ($urandom_range(0, 7) == 0) ? (CW-1)'($urandom_range(0, lb)) :
                (CW-1)'(lb + $urandom_range(0, 32'h00080000));
        bond  = 1'($urandom_range(0, 1));
        frac  = RB'($urandom);
        mask  = 2'($urandom_range(0, 3));
        for (int i = 0; i < 3; i++)
            pending_reqs.push_back(make_req(ax1[i], ax2[i], ax2[i] - ax1[i], pdist, lb, ub,
                                            bond, frac, mask));
    endtask

    task automatic queue_noise();
        pending_reqs.push_back(make_req($urandom, $urandom, $urandom,
                                        (CW-1)'($urandom), (CW-1)'($urandom),
                                        (CW-1)'($urandom), 1'($urandom),
                                        RB'($urandom), 2'($urandom)));
    endtask

    task automatic queue_random(input int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                queue_pair();
                n += 3;
            end
            else
            begin
                queue_noise();
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_pos.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_directed();
        logic [1:0] m;
        // every mask at field extremes and zero distance
        for (int i = 0; i < 4; i++)
        begin
            m = 2'(i);
            pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, m));
            pending_reqs.push_back(make_req(32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                                            31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                                            1, 16'hffff, m));
            pending_reqs.push_back(make_req(32'sh00010000, 32'sh00050000, 32'sh00040000,
                                            0, 31'h00020000, 31'h00030000, 0, 16'h8000, m));
            // huge offset from tiny distance
            pending_reqs.push_back(make_req(32'sh12345678, 32'sh7fffffff, 32'sh7fffffff,
                                            1, 31'h7fff0000, 31'h7fffffff, 0, 16'hffff, m));
        end
        // upper below lower, bond and plain
        pending_reqs.push_back(make_req(32'sh00010000, 32'sh00030000, 32'sh00020000,
                                        31'h00020000, 31'h00050000, 31'h00010000,
                                        0, 16'hc000, FIX_NONE));
        pending_reqs.push_back(make_req(32'sh00010000, 32'sh00030000, 32'sh00020000,
                                        31'h00020000, 31'h00050000, 31'h00010000,
                                        1, 16'hc000, FIX_FIRST));
        // negative odd difference
        pending_reqs.push_back(make_req(32'sh00000005, -32'sh00000002, -32'sh00000007,
                                        31'h7, 31'h3, 31'h9, 1, 16'h1234, FIX_NONE));
        pending_reqs.push_back(make_req(-32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                        31'h7fffffff, 0, 31'h7fffffff, 0, 16'h0001,
                                        FIX_SECOND));
    endtask

    // stimulus sequence
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        x1_coord        = '0;
        x2_coord        = '0;
        diff_coord      = '0;
        pair_distance   = '0;
        lower_bound     = '0;
        upper_bound     = '0;
        is_bond         = 1'b0;
        random_fraction = '0;
        fixed_mask      = FIX_NONE;
        cfg_valid       = 1'b0;
        cfg_data        = 1'b0;
        mode_q          = 1'b0;
        hold_off        = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        burst_left      = 1;
        gap_left        = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mode(1'b0);
        queue_directed();
        queue_random(700);
        // sender holds off until every result is back
        while (pending_reqs.size() > 300)
            @(posedge clk);
        hold_off = 1'b1;
        while (expected_pos.size() > 0)
            @(posedge clk);
        hold_off = 1'b0;
        wait_drained();

        write_mode(1'b1);
        queue_directed();
        queue_random(400);
        wait_drained();

        write_mode(1'b0);
        queue_random(650);
        wait_drained();

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rdbc_pkg.sv
hdl/random_distance_bound_correction.sv
tb/random_distance_bound_correction_tb.sv
